### hdl/smpq_pkg.sv
// Package: shared constants, types and status codes for the sorted min-priority queue.
`timescale 1ns / 1ps

package smpq_pkg;

  localparam int unsigned CAPACITY       = 64;
  localparam int unsigned ITEM_WIDTH     = 32;
  localparam int unsigned PRIORITY_WIDTH = 32;

  // Only the bits that survive both the input mask and the 32-bit result field are kept.
  localparam int unsigned ITEM_STORE_W = (ITEM_WIDTH < 32) ? ITEM_WIDTH : 32;
  localparam int unsigned PRIO_STORE_W = (PRIORITY_WIDTH < 32) ? PRIORITY_WIDTH : 32;

  localparam int unsigned ADDR_W  = $clog2(CAPACITY);
  localparam int unsigned COUNT_W = $clog2(CAPACITY + 1);

  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 72;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    logic [PRIO_STORE_W-1:0] prio;
    logic [ITEM_STORE_W-1:0] item;
  } entry_t;

endpackage

### hdl/smpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module smpq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hdl/sorted_min_priority_queue.sv
// Top level: sorted min-priority queue over a single RAM with a compare-and-shift sequencer.
`timescale 1ns / 1ps

// Bounded min-priority queue of smpq_pkg::CAPACITY entries kept in ascending priority order
// in one RAM; equal priorities leave in arrival order. Every command gives one result.
// Commands are taken one at a time, and s_axis_tready_o is low while one is in work. The
// result is loaded at the edge where s_axis_tready_o rises again. An insert into a queue
// of n entries walks down from the tail with one RAM read and one compare per step and
// shifts each entry whose priority is above the new one up one place. It stops at an entry
// of lower or equal priority or lands at the head; on an empty queue the new entry is
// written at once. A remove reads the head and moves each remaining entry down one place.
// Inserts on a full queue and removes on an empty one go straight to the result. The
// longest commands are an insert at the head of 63 entries and a remove from a full queue.
// The pace is set by the RAM's registered read port, which serves one access per step. The
// result sits in an output register, so the next command is accepted while it waits; the
// sequencer only holds at its last step if that register is still occupied.
module sorted_min_priority_queue (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [smpq_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,   // [31:0] item_value,
                                                             // [63:32] priority_key
  input  logic                            s_axis_tuser_i,   // [0] cmd
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [smpq_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,   // [31:0] out_item,
                                                             // [63:32] out_priority,
                                                             // [64] now_empty, [71:65] zero
  output logic [1:0]                      m_axis_tuser_o    // [1:0] status
);

  localparam int unsigned AW = smpq_pkg::ADDR_W;
  localparam int unsigned CW = smpq_pkg::COUNT_W;
  localparam int unsigned IW = smpq_pkg::ITEM_STORE_W;
  localparam int unsigned PW = smpq_pkg::PRIO_STORE_W;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_INS_RD   = 8'b0000_0010,
    S_INS_CMP  = 8'b0000_0100,
    S_INS_PUT  = 8'b0000_1000,
    S_REM_HEAD = 8'b0001_0000,
    S_REM_RD   = 8'b0010_0000,
    S_REM_MV   = 8'b0100_0000,
    S_EMIT     = 8'b1000_0000
  } state_e;

  state_e             state_q, state_d;
  logic [CW-1:0]      count_q, count_d;
  logic [AW-1:0]      k_q, k_d;
  smpq_pkg::entry_t   new_q, new_d;
  smpq_pkg::status_e  res_status_q, res_status_d;
  logic [IW-1:0]      res_item_q, res_item_d;
  logic [PW-1:0]      res_prio_q, res_prio_d;

  logic                            out_valid_q, out_valid_d;
  logic [smpq_pkg::OUT_TDATA_W-1:0] out_data_q, out_data_d;
  logic [1:0]                      out_user_q, out_user_d;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  smpq_pkg::entry_t   ram_wdata, ram_rdata;
  logic [$bits(smpq_pkg::entry_t)-1:0] ram_rdata_raw;

  logic               in_accept;
  logic               out_load;
  logic               rd_above;
  smpq_pkg::entry_t   in_entry;

  assign ram_rdata = smpq_pkg::entry_t'(ram_rdata_raw);

  smpq_ram #(
    .WIDTH ($bits(smpq_pkg::entry_t)),
    .DEPTH (smpq_pkg::CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign in_entry.item   = s_axis_tdata_i[IW-1:0];
  assign in_entry.prio   = s_axis_tdata_i[32 +: PW];

  // The one comparator: is the stored entry strictly above the new priority?
  assign rd_above = (ram_rdata.prio > new_q.prio);

  assign out_load = (state_q == S_EMIT) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    k_d          = k_q;
    new_d        = new_q;
    res_status_d = res_status_q;
    res_item_d   = res_item_q;
    res_prio_d   = res_prio_q;
    ram_we       = 1'b0;
    ram_waddr    = k_q;
    ram_wdata    = new_q;
    ram_raddr    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          new_d      = in_entry;
          res_item_d = '0;
          res_prio_d = '0;
          k_d        = AW'(count_q);
          if (s_axis_tuser_i == smpq_pkg::CMD_INSERT) begin
            if (count_q == CW'(smpq_pkg::CAPACITY)) begin
              res_status_d = smpq_pkg::ST_FULL;
              state_d      = S_EMIT;
            end else if (count_q == '0) begin
              ram_we       = 1'b1;
              ram_waddr    = '0;
              ram_wdata    = in_entry;
              count_d      = count_q + CW'(1);
              res_status_d = smpq_pkg::ST_INSERTED;
              state_d      = S_EMIT;
            end else begin
              state_d = S_INS_RD;
            end
          end else begin
            if (count_q == '0) begin
              res_status_d = smpq_pkg::ST_EMPTY;
              state_d      = S_EMIT;
            end else begin
              // head is being read at address zero this cycle
              res_status_d = smpq_pkg::ST_REMOVED;
              state_d      = S_REM_HEAD;
            end
          end
        end
      end

      S_INS_RD: begin
        ram_raddr = k_q - AW'(1);
        state_d   = S_INS_CMP;
      end

      S_INS_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = k_q;
        if (rd_above) begin
          // shift the larger entry up one place, then keep walking down or place the new entry at the head
          ram_wdata = ram_rdata;
          if (k_q == AW'(1)) begin
            state_d = S_INS_PUT;
          end else begin
            k_d     = k_q - AW'(1);
            state_d = S_INS_RD;
          end
        end else begin
          ram_wdata    = new_q;
          count_d      = count_q + CW'(1);
          res_status_d = smpq_pkg::ST_INSERTED;
          state_d      = S_EMIT;
        end
      end

      S_INS_PUT: begin
        ram_we       = 1'b1;
        ram_waddr    = '0;
        ram_wdata    = new_q;
        count_d      = count_q + CW'(1);
        res_status_d = smpq_pkg::ST_INSERTED;
        state_d      = S_EMIT;
      end

      S_REM_HEAD: begin
        res_item_d = ram_rdata.item;
        res_prio_d = ram_rdata.prio;
        if (count_q == CW'(1)) begin
          count_d = count_q - CW'(1);
          state_d = S_EMIT;
        end else begin
          k_d     = AW'(1);
          state_d = S_REM_RD;
        end
      end

      S_REM_RD: begin
        ram_raddr = k_q;
        state_d   = S_REM_MV;
      end

      S_REM_MV: begin
        ram_we    = 1'b1;
        ram_waddr = k_q - AW'(1);
        ram_wdata = ram_rdata;
        if (CW'(k_q) + CW'(1) == count_q) begin
          count_d = count_q - CW'(1);
          state_d = S_EMIT;
        end else begin
          k_d     = k_q + AW'(1);
          state_d = S_REM_RD;
        end
      end

      S_EMIT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      out_data_d  = {7'b0, (count_q == '0), 32'(res_prio_q), 32'(res_item_q)};
      out_user_d  = res_status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q          <= k_d;
    new_q        <= new_d;
    res_status_q <= res_status_d;
    res_item_q   <= res_item_d;
    res_prio_q   <= res_prio_d;
    out_data_q   <= out_data_d;
    out_user_q   <= out_user_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(smpq_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (CW'(ram_waddr) <= count_q))
    else $error("store write beyond the filled region");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (res_status_q == smpq_pkg::ST_EMPTY)) |=> out_data_q[64])
    else $error("remove on empty without empty flag");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !s_axis_tready_o)
    else $error("new command taken while one is in work");

endmodule
